// File: src/lsee_pkg.sv
// ----------------------------------------------------------------------------
// lsee_pkg
// Shared types, widths and codes for the line segment edge extender.
// ----------------------------------------------------------------------------
package lsee_pkg;

	localparam int COORD_BITS = 12;
	localparam int CFG_BITS   = 12;
	localparam int OUT_BITS   = 16;
	localparam int IDX_BITS   = 2;

	// Derived datapath widths
	localparam int DIFF_BITS = COORD_BITS + 1;     // signed dx, dy
	localparam int NUM1_BITS = 2 * COORD_BITS;     // |y1*x2 - y2*x1|
	localparam int B_BITS    = 2 * COORD_BITS + 1; // signed intercept
	localparam int OP_BITS   = B_BITS + 1;         // signed height - b
	localparam int FW_BITS   = 2 * COORD_BITS + 2; // signed dy * width
	localparam int PROD_BITS = OP_BITS + DIFF_BITS;
	localparam int NUM2_BITS = 3 * COORD_BITS + 1; // second dividend magnitude
	localparam int VAL_BITS  = 3 * COORD_BITS + 2; // signed extended coordinate

	// Register indexes
	localparam logic [IDX_BITS-1:0] REG_EDGE_MARGIN  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [CFG_BITS-1:0] EDGE_MARGIN_RST  = 12'd150;
	localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 12'd480;

	typedef enum logic [1:0] {
		EDGE_NONE   = 2'd0,
		EDGE_BOTTOM = 2'd1,
		EDGE_LEFT   = 2'd2,
		EDGE_RIGHT  = 2'd3
	} edge_t;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_in_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] new_start_x;
		logic signed [OUT_BITS-1:0] new_start_y;
		logic signed [OUT_BITS-1:0] new_end_x;
		logic signed [OUT_BITS-1:0] new_end_y;
		logic [1:0]                 edge_taken;
		logic                       degenerate_flag;
		logic                       saturated_flag;
	} seg_out_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] margin;
		logic [CFG_BITS-1:0] width;
		logic [CFG_BITS-1:0] height;
	} frame_cfg_t;

	// Sideband that travels alongside the dividers
	typedef struct packed {
		coord_t                      x1;
		coord_t                      y1;
		coord_t                      x2;
		coord_t                      y2;
		logic signed [DIFF_BITS-1:0] dx;
		logic signed [DIFF_BITS-1:0] dy;
		logic signed [B_BITS-1:0]    b;
		edge_t                       edge_sel;
		logic                        degen;
		logic                        move_start;
		logic                        q_neg;
	} seg_side_t;

	localparam int SIDE_BITS = $bits(seg_side_t);

endpackage

// File: src/line_segment_edge_extend.sv
// ----------------------------------------------------------------------------
// line_segment_edge_extend
// Stretches a detected line segment to the bottom, left or right frame edge.
// ----------------------------------------------------------------------------
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------
//  segment   | start / busy          | seg_in_t  (two endpoints)
//  result    | done (one-cycle pulse)| seg_out_t (extended endpoints)
//  config    | wr_en                 | wr_index, wr_data
//
//  One segment is taken every cycle; busy is never raised. Each result
//  passes the front end, the intercept divider (2*COORD_BITS stages),
//  the middle stages, the edge divider (3*COORD_BITS + 1 stages) and the
//  result register; both dividers are bit-per-stage. Reset clears every
//  valid bit and loads the register defaults. The receiver cannot stall,
//  so the pipe only advances.
//
module line_segment_edge_extend import lsee_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  seg_in_t             segment,
	output logic                done,
	output seg_out_t            result,
	input  logic                wr_en,
	input  logic [IDX_BITS-1:0] wr_index,
	input  logic [CFG_BITS-1:0] wr_data
);

	localparam int LATENCY = 5 * COORD_BITS + 7;

	// Configuration registers
	frame_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.margin <= EDGE_MARGIN_RST;
			cfg_q.width  <= FRAME_WIDTH_RST;
			cfg_q.height <= FRAME_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EDGE_MARGIN:  cfg_q.margin <= wr_data;
				REG_FRAME_WIDTH:  cfg_q.width  <= wr_data;
				REG_FRAME_HEIGHT: cfg_q.height <= wr_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	// Fully pipelined: a transfer can happen in every cycle
	assign busy = 1'b0;

	// Front end: differences, edge choice, intercept dividend
	logic                  p_vld;
	logic [NUM1_BITS-1:0]  p_num;
	logic [COORD_BITS-1:0] p_den;
	seg_side_t             p_side;

	lsee_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (start && !busy),
		.seg    (segment),
		.cfg    (cfg_q),
		.vld    (p_vld),
		.num    (p_num),
		.den    (p_den),
		.side   (p_side)
	);

	// Intercept divider: |y1*x2 - y2*x1| / |dx|
	logic                  d1_vld;
	logic [NUM1_BITS-1:0]  d1_quo;
	logic [SIDE_BITS-1:0]  d1_side;

	lsee_div_pipe #(
		.NUM_W  (NUM1_BITS),
		.DEN_W  (COORD_BITS),
		.SIDE_W (SIDE_BITS)
	) u_div_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (p_vld),
		.num     (p_num),
		.den     (p_den),
		.side_in (p_side),
		.vld     (d1_vld),
		.quo     (d1_quo),
		.side    (d1_side)
	);

	// Middle: signed intercept, products and edge dividend
	logic                  m_vld;
	logic [NUM2_BITS-1:0]  m_num;
	logic [COORD_BITS-1:0] m_den;
	seg_side_t             m_side;

	lsee_mid u_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (d1_vld),
		.quo     (d1_quo),
		.side_in (seg_side_t'(d1_side)),
		.cfg     (cfg_q),
		.vld     (m_vld),
		.num     (m_num),
		.den     (m_den),
		.side    (m_side)
	);

	// Edge divider: bottom x or right y
	logic                  d2_vld;
	logic [NUM2_BITS-1:0]  d2_quo;
	logic [SIDE_BITS-1:0]  d2_side_raw;
	seg_side_t             d2_side;

	lsee_div_pipe #(
		.NUM_W  (NUM2_BITS),
		.DEN_W  (COORD_BITS),
		.SIDE_W (SIDE_BITS)
	) u_div_e (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (m_vld),
		.num     (m_num),
		.den     (m_den),
		.side_in (m_side),
		.vld     (d2_vld),
		.quo     (d2_quo),
		.side    (d2_side_raw)
	);

	assign d2_side = seg_side_t'(d2_side_raw);

	// Final stage: sign the quotient or take the intercept, clip to 16 bits, place the endpoints
	localparam logic signed [VAL_BITS-1:0] SAT_MAX = VAL_BITS'(2 ** (OUT_BITS - 1) - 1);
	localparam logic signed [VAL_BITS-1:0] SAT_MIN = -SAT_MAX - VAL_BITS'(1);

	logic signed [VAL_BITS-1:0] qs_c, val_c;
	logic                       hi_c, lo_c;
	logic signed [OUT_BITS-1:0] v16_c;
	seg_out_t                   res_c;

	assign qs_c  = signed'({1'b0, d2_quo});
	assign val_c = (d2_side.edge_sel == EDGE_LEFT) ? VAL_BITS'(d2_side.b)
		: (d2_side.q_neg ? -qs_c : qs_c);
	assign hi_c  = val_c > SAT_MAX;
	assign lo_c  = val_c < SAT_MIN;
	assign v16_c = hi_c ? OUT_BITS'(SAT_MAX) : (lo_c ? OUT_BITS'(SAT_MIN) : val_c[OUT_BITS-1:0]);

	always_comb begin
		res_c.new_start_x     = OUT_BITS'(d2_side.x1);
		res_c.new_start_y     = OUT_BITS'(d2_side.y1);
		res_c.new_end_x       = OUT_BITS'(d2_side.x2);
		res_c.new_end_y       = OUT_BITS'(d2_side.y2);
		res_c.edge_taken      = d2_side.edge_sel;
		res_c.degenerate_flag = d2_side.degen;
		res_c.saturated_flag  = 1'b0;
		case (d2_side.edge_sel)
			EDGE_BOTTOM: begin
				// the lower endpoint moves; on equal y the second one
				if (d2_side.move_start) begin
					res_c.new_start_x = v16_c;
					res_c.new_start_y = OUT_BITS'(cfg_q.height);
				end else begin
					res_c.new_end_x = v16_c;
					res_c.new_end_y = OUT_BITS'(cfg_q.height);
				end
				res_c.saturated_flag = hi_c || lo_c;
			end
			EDGE_LEFT: begin
				res_c.new_start_x    = '0;
				res_c.new_start_y    = v16_c;
				res_c.saturated_flag = hi_c || lo_c;
			end
			EDGE_RIGHT: begin
				res_c.new_end_x      = OUT_BITS'(cfg_q.width);
				res_c.new_end_y      = v16_c;
				res_c.saturated_flag = hi_c || lo_c;
			end
			default: ; // unchanged segment passes through
		endcase
	end

	seg_out_t res_q;
	logic     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_c;
	end

	assign done   = done_q;
	assign result = res_q;

	// Every accepted segment yields its result, and every result has a matching transfer
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result missing after segment transfer");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching segment transfer");

	// A blocked extension leaves the segment untouched and unclipped
	a_degen_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate_flag |->
		result.edge_taken == EDGE_NONE && !result.saturated_flag)
		else $error("degenerate result carries an edge or clip");

	a_sat_needs_edge: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.saturated_flag |-> result.edge_taken != EDGE_NONE)
		else $error("clip flagged on an unchanged segment");

endmodule

// File: src/lsee_div_pipe.sv
// ----------------------------------------------------------------------------
// lsee_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module lsee_div_pipe #(
	parameter int NUM_W  = 24,
	parameter int DEN_W  = 12,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] side
);

	logic              vld_s  [NUM_W];
	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [NUM_W-1:0]  nq_s   [NUM_W];
	logic [DEN_W-1:0]  den_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic              vld_p;
		logic [DEN_W-1:0]  rem_p;
		logic [NUM_W-1:0]  nq_p;
		logic [DEN_W-1:0]  den_p;
		logic [SIDE_W-1:0] side_p;
		logic [DEN_W:0]    trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_p  = vld_in;
			assign rem_p  = '0;
			assign nq_p   = num;
			assign den_p  = den;
			assign side_p = side_in;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign nq_p   = nq_s[k-1];
			assign den_p  = den_s[k-1];
			assign side_p = side_s[k-1];
		end

		// shift in the next dividend bit, subtract where it fits
		assign trial = {rem_p, nq_p[NUM_W-1]};
		assign ge    = trial >= {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? DEN_W'(trial - {1'b0, den_p}) : DEN_W'(trial);
			nq_s[k]   <= {nq_p[NUM_W-2:0], ge};
			den_s[k]  <= den_p;
			side_s[k] <= side_p;
		end
	end

	assign vld  = vld_s[NUM_W-1];
	assign quo  = nq_s[NUM_W-1];
	assign side = side_s[NUM_W-1];

endmodule

// File: src/lsee_prep.sv
// ----------------------------------------------------------------------------
// lsee_prep
// Differences, edge decision and intercept dividend for one segment.
// ----------------------------------------------------------------------------
module lsee_prep import lsee_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_in,
	input  seg_in_t               seg,
	input  frame_cfg_t            cfg,
	output logic                  vld,
	output logic [NUM1_BITS-1:0]  num,
	output logic [COORD_BITS-1:0] den,
	output seg_side_t             side
);

	// stage 1
	logic signed [DIFF_BITS-1:0] dx_c, dy_c, bline_c;
	logic [NUM1_BITS-1:0]        pa_c, pb_c;
	logic                        near_bot_c, near_left_c;

	logic                        vld_s1;
	seg_in_t                     seg_s1;
	logic signed [DIFF_BITS-1:0] dx_s1, dy_s1;
	logic [NUM1_BITS-1:0]        pa_s1, pb_s1;
	logic                        near_bot_s1, near_left_s1;

	assign dx_c    = signed'({1'b0, seg.end_x}) - signed'({1'b0, seg.start_x});
	assign dy_c    = signed'({1'b0, seg.end_y}) - signed'({1'b0, seg.start_y});
	assign bline_c = signed'({1'b0, cfg.height}) - signed'({1'b0, cfg.margin});
	assign pa_c    = NUM1_BITS'(seg.start_y) * NUM1_BITS'(seg.end_x);
	assign pb_c    = NUM1_BITS'(seg.end_y) * NUM1_BITS'(seg.start_x);
	assign near_bot_c = (signed'({1'b0, seg.start_y}) > bline_c)
		|| (signed'({1'b0, seg.end_y}) > bline_c);
	assign near_left_c = seg.start_x < cfg.margin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		seg_s1       <= seg;
		dx_s1        <= dx_c;
		dy_s1        <= dy_c;
		pa_s1        <= pa_c;
		pb_s1        <= pb_c;
		near_bot_s1  <= near_bot_c;
		near_left_s1 <= near_left_c;
	end

	// stage 2
	logic signed [B_BITS-1:0]    num1_c, num1_abs_c;
	logic signed [DIFF_BITS-1:0] dx_abs_c;
	logic                        dx_zero_c, degen_c, neg_slope_c;
	edge_t                       edge_c;
	seg_side_t                   side_c;

	assign num1_c     = signed'({1'b0, pa_s1}) - signed'({1'b0, pb_s1});
	assign num1_abs_c = num1_c[B_BITS-1] ? -num1_c : num1_c;
	assign dx_abs_c   = dx_s1[DIFF_BITS-1] ? -dx_s1 : dx_s1;
	assign dx_zero_c  = dx_s1 == '0;
	assign degen_c    = dx_zero_c || (near_bot_s1 && (dy_s1 == '0));
	assign neg_slope_c = (!dx_s1[DIFF_BITS-1] && !dx_zero_c) != !dy_s1[DIFF_BITS-1];

	always_comb begin
		if (degen_c) begin
			edge_c = EDGE_NONE;
		end else if (near_bot_s1) begin
			edge_c = EDGE_BOTTOM;
		end else if (near_left_s1 || neg_slope_c) begin
			edge_c = EDGE_LEFT;
		end else begin
			edge_c = EDGE_RIGHT;
		end
	end

	always_comb begin
		side_c.x1         = seg_s1.start_x;
		side_c.y1         = seg_s1.start_y;
		side_c.x2         = seg_s1.end_x;
		side_c.y2         = seg_s1.end_y;
		side_c.dx         = dx_s1;
		side_c.dy         = dy_s1;
		side_c.b          = '0;
		side_c.edge_sel   = edge_c;
		side_c.degen      = degen_c;
		side_c.move_start = seg_s1.start_y > seg_s1.end_y;
		side_c.q_neg      = num1_c[B_BITS-1] ^ dx_s1[DIFF_BITS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else begin
			vld <= vld_s1;
		end
	end

	// hold the divisor at one for a vertical segment, its result is dropped
	always_ff @(posedge clk) begin
		num  <= num1_abs_c[NUM1_BITS-1:0];
		den  <= dx_zero_c ? COORD_BITS'(1) : dx_abs_c[COORD_BITS-1:0];
		side <= side_c;
	end

endmodule

// File: src/lsee_mid.sv
// ----------------------------------------------------------------------------
// lsee_mid
// Signs the intercept and forms the dividend for the bottom or right edge.
// ----------------------------------------------------------------------------
module lsee_mid import lsee_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_in,
	input  logic [NUM1_BITS-1:0]  quo,
	input  seg_side_t             side_in,
	input  frame_cfg_t            cfg,
	output logic                  vld,
	output logic [NUM2_BITS-1:0]  num,
	output logic [COORD_BITS-1:0] den,
	output seg_side_t             side
);

	// stage 3: intercept and first operand
	logic signed [B_BITS-1:0]  qs_c, b_c;
	logic signed [OP_BITS-1:0] h_c, op_c;
	logic signed [FW_BITS-1:0] dyfw_c;
	seg_side_t                 side_c;

	logic                      vld_s3;
	seg_side_t                 side_s3;
	logic signed [OP_BITS-1:0] op_s3;
	logic signed [FW_BITS-1:0] dyfw_s3;

	assign qs_c   = signed'({1'b0, quo});
	assign b_c    = side_in.q_neg ? -qs_c : qs_c;
	assign h_c    = OP_BITS'({1'b0, cfg.height});
	assign op_c   = (side_in.edge_sel == EDGE_BOTTOM) ? h_c - OP_BITS'(b_c) : OP_BITS'(b_c);
	assign dyfw_c = FW_BITS'(side_in.dy) * FW_BITS'(signed'({1'b0, cfg.width}));

	always_comb begin
		side_c   = side_in;
		side_c.b = b_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_c;
		op_s3   <= op_c;
		dyfw_s3 <= dyfw_c;
	end

	// stage 4: product with the run
	logic                        vld_s4;
	seg_side_t                   side_s4;
	logic signed [PROD_BITS-1:0] prod_s4;
	logic signed [FW_BITS-1:0]   dyfw_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		prod_s4 <= PROD_BITS'(op_s3) * PROD_BITS'(side_s3.dx);
		dyfw_s4 <= dyfw_s3;
	end

	// stage 5: dividend magnitude, divisor and quotient sign
	logic                        bottom_c;
	logic signed [PROD_BITS-1:0] num2_c, num2_abs_c;
	logic signed [DIFF_BITS-1:0] dsel_c, dabs_c;
	seg_side_t                   side5_c;

	assign bottom_c   = side_s4.edge_sel == EDGE_BOTTOM;
	assign num2_c     = bottom_c ? prod_s4 : prod_s4 + PROD_BITS'(dyfw_s4);
	assign num2_abs_c = num2_c[PROD_BITS-1] ? -num2_c : num2_c;
	assign dsel_c     = bottom_c ? side_s4.dy : side_s4.dx;
	assign dabs_c     = dsel_c[DIFF_BITS-1] ? -dsel_c : dsel_c;

	always_comb begin
		side5_c       = side_s4;
		side5_c.q_neg = num2_c[PROD_BITS-1] ^ dsel_c[DIFF_BITS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else begin
			vld <= vld_s4;
		end
	end

	// a blocked or left-edge item needs no second quotient: divide by one
	always_ff @(posedge clk) begin
		num  <= num2_abs_c[NUM2_BITS-1:0];
		den  <= (side_s4.degen || side_s4.edge_sel == EDGE_LEFT)
			? COORD_BITS'(1) : dabs_c[COORD_BITS-1:0];
		side <= side5_c;
	end

endmodule
